// File: rtl/imhpq_pkg.sv
package imhpq_pkg;

    localparam int MAX_ELEMENTS = 256;
    localparam int ID_W         = 9;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int KEY_W        = 32;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_CHANGE = 2'd2;
    localparam logic [1:0] KIND_LOOKUP = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    typedef struct packed {
        logic [1:0]              kind;
        logic [ID_W-1:0]         element;
        logic signed [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic [1:0]              status;
        logic                    is_empty;
        logic [ID_W-1:0]         count;
        logic [ID_W-1:0]         min_element;
        logic signed [KEY_W-1:0] min_key;
        logic                    elem_present;
        logic signed [KEY_W-1:0] elem_key;
    } rsp_t;

    typedef struct packed {
        logic [ID_W-1:0]         element;
        logic signed [KEY_W-1:0] key;
    } slot_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_INS,
        CMD_CHG,
        CMD_RM_A,
        CMD_RM_B,
        CMD_RM_C,
        CMD_PUT_S,
        CMD_UP_RD,
        CMD_UP_MOVE,
        CMD_DN_RD_L,
        CMD_DN_L,
        CMD_DN_TAKE_R,
        CMD_DN_MOVE,
        CMD_FIN_A,
        CMD_FIN_B
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       fin;
        logic [1:0] status;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic id_ok;
        logic present;
        logic full;
        logic empty;
        logic at_root;
        logic no_child;
        logic has_right;
        logic hrd_gt_s;
        logic key_lt_old;
        logic key_gt_old;
        logic right_lt;
        logic s_gt_child;
        logic out_busy;
    } stat_t;

endpackage

// File: rtl/imhpq_ctrl.sv
module imhpq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  imhpq_pkg::stat_t stat,
    output imhpq_pkg::cmd_t  cmd
);

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_POS    = 15'b000000000000010,
        S_RM_B   = 15'b000000000000100,
        S_RM_C   = 15'b000000000001000,
        S_RM_D   = 15'b000000000010000,
        S_CK     = 15'b000000000100000,
        S_UP_RD  = 15'b000000001000000,
        S_UP_CMP = 15'b000000010000000,
        S_DN_L   = 15'b000000100000000,
        S_DN_R   = 15'b000001000000000,
        S_DN_RC  = 15'b000010000000000,
        S_DN_CMP = 15'b000100000000000,
        S_FIN_A  = 15'b001000000000000,
        S_FIN_B  = 15'b010000000000000,
        S_FIN_C  = 15'b100000000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] status_reg, status_next;

    // state and status registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= imhpq_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

    // sequencing of heap operations
    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd.op      = imhpq_pkg::CMD_NONE;
        cmd.fin     = 1'b0;
        cmd.status  = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                status_next = imhpq_pkg::ST_OK;
                if (req_valid)
                begin
                    cmd.op     = imhpq_pkg::CMD_LOAD;
                    state_next = S_POS;
                end
            end
            S_POS:
            begin
                case (stat.kind)
                    imhpq_pkg::KIND_INSERT:
                    begin
                        if (!stat.id_ok || stat.present || stat.full)
                        begin
                            status_next = imhpq_pkg::ST_FULL;
                            state_next  = S_FIN_A;
                        end
                        else
                        begin
                            cmd.op     = imhpq_pkg::CMD_INS;
                            state_next = S_UP_RD;
                        end
                    end
                    imhpq_pkg::KIND_REMOVE:
                    begin
                        if (stat.empty)
                        begin
                            status_next = imhpq_pkg::ST_EMPTY;
                            state_next  = S_FIN_A;
                        end
                        else
                        begin
                            cmd.op     = imhpq_pkg::CMD_RM_A;
                            state_next = S_RM_B;
                        end
                    end
                    imhpq_pkg::KIND_CHANGE:
                    begin
                        if (!stat.present)
                        begin
                            status_next = imhpq_pkg::ST_ABSENT;
                            state_next  = S_FIN_A;
                        end
                        else
                        begin
                            cmd.op     = imhpq_pkg::CMD_CHG;
                            state_next = S_CK;
                        end
                    end
                    default:
                    begin
                        if (!stat.present)
                        begin
                            status_next = imhpq_pkg::ST_ABSENT;
                        end
                        state_next = S_FIN_A;
                    end
                endcase
            end
            S_RM_B:
            begin
                cmd.op     = imhpq_pkg::CMD_RM_B;
                state_next = S_RM_C;
            end
            S_RM_C:
            begin
                cmd.op     = imhpq_pkg::CMD_RM_C;
                state_next = S_RM_D;
            end
            S_RM_D:
            begin
                state_next = stat.empty ? S_FIN_A : S_DN_L;
            end
            S_CK:
            begin
                if (stat.key_lt_old)
                begin
                    state_next = S_UP_RD;
                end
                else if (stat.key_gt_old)
                begin
                    state_next = S_DN_L;
                end
                else
                begin
                    cmd.op     = imhpq_pkg::CMD_PUT_S;
                    state_next = S_FIN_A;
                end
            end
            S_UP_RD:
            begin
                if (stat.at_root)
                begin
                    cmd.op     = imhpq_pkg::CMD_PUT_S;
                    state_next = S_FIN_A;
                end
                else
                begin
                    cmd.op     = imhpq_pkg::CMD_UP_RD;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (stat.hrd_gt_s)
                begin
                    cmd.op     = imhpq_pkg::CMD_UP_MOVE;
                    state_next = S_UP_RD;
                end
                else
                begin
                    cmd.op     = imhpq_pkg::CMD_PUT_S;
                    state_next = S_FIN_A;
                end
            end
            S_DN_L:
            begin
                if (stat.no_child)
                begin
                    cmd.op     = imhpq_pkg::CMD_PUT_S;
                    state_next = S_FIN_A;
                end
                else
                begin
                    cmd.op     = imhpq_pkg::CMD_DN_RD_L;
                    state_next = S_DN_R;
                end
            end
            S_DN_R:
            begin
                cmd.op     = imhpq_pkg::CMD_DN_L;
                state_next = stat.has_right ? S_DN_RC : S_DN_CMP;
            end
            S_DN_RC:
            begin
                if (stat.right_lt)
                begin
                    cmd.op = imhpq_pkg::CMD_DN_TAKE_R;
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (stat.s_gt_child)
                begin
                    cmd.op     = imhpq_pkg::CMD_DN_MOVE;
                    state_next = S_DN_L;
                end
                else
                begin
                    cmd.op     = imhpq_pkg::CMD_PUT_S;
                    state_next = S_FIN_A;
                end
            end
            S_FIN_A:
            begin
                cmd.op     = imhpq_pkg::CMD_FIN_A;
                state_next = S_FIN_B;
            end
            S_FIN_B:
            begin
                cmd.op     = imhpq_pkg::CMD_FIN_B;
                state_next = S_FIN_C;
            end
            S_FIN_C:
            begin
                // output still held: read the result again
                if (!stat.out_busy)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_FIN_A;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/imhpq_dp.sv
module imhpq_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  imhpq_pkg::req_t  req,
    input  imhpq_pkg::cmd_t  cmd,
    output imhpq_pkg::stat_t stat,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output imhpq_pkg::rsp_t  rsp
);

    localparam int AW = imhpq_pkg::ADDR_W;
    localparam int IW = imhpq_pkg::ID_W;

    // heap slots and element-to-slot map
    imhpq_pkg::slot_t heap_mem [imhpq_pkg::MAX_ELEMENTS];
    logic [IW-1:0]    pos_mem  [imhpq_pkg::MAX_ELEMENTS];

    logic [imhpq_pkg::MAX_ELEMENTS-1:0] vld_reg;
    logic [IW-1:0]    cnt_reg;
    imhpq_pkg::req_t  op_reg;
    imhpq_pkg::slot_t s_reg, c_reg, root_reg, hrd_reg;
    logic [IW-1:0]    idx_reg, cidx_reg, prd_reg;
    logic             rsp_valid_reg;
    imhpq_pkg::rsp_t  rsp_reg;

    logic [IW:0]      dbl_idx;
    logic [AW-1:0]    op_addr;
    logic [AW-1:0]    hrd_addr;
    logic             hwr_en;
    imhpq_pkg::slot_t hwr_data;
    logic             present;

    assign dbl_idx = {idx_reg, 1'b0};
    assign op_addr = AW'(op_reg.element - IW'(1));
    assign present = stat.id_ok && vld_reg[op_addr];

    // heap read address
    always_comb
    begin
        case (cmd.op)
            imhpq_pkg::CMD_CHG:     hrd_addr = AW'(prd_reg - IW'(1));
            imhpq_pkg::CMD_RM_A:    hrd_addr = AW'(cnt_reg - IW'(1));
            imhpq_pkg::CMD_UP_RD:   hrd_addr = AW'((idx_reg >> 1) - IW'(1));
            imhpq_pkg::CMD_DN_RD_L: hrd_addr = AW'(dbl_idx - (IW+1)'(1));
            imhpq_pkg::CMD_DN_L:    hrd_addr = AW'(dbl_idx);
            imhpq_pkg::CMD_FIN_B:   hrd_addr = AW'(prd_reg - IW'(1));
            default:                hrd_addr = '0;
        endcase
    end

    // heap write selection
    always_comb
    begin
        hwr_en   = 1'b1;
        hwr_data = s_reg;
        case (cmd.op)
            imhpq_pkg::CMD_PUT_S:   hwr_data = s_reg;
            imhpq_pkg::CMD_UP_MOVE: hwr_data = hrd_reg;
            imhpq_pkg::CMD_DN_MOVE: hwr_data = c_reg;
            default:                hwr_en   = 1'b0;
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        hrd_reg <= heap_mem[hrd_addr];
        if (hwr_en)
        begin
            heap_mem[AW'(idx_reg - IW'(1))]       <= hwr_data;
            pos_mem[AW'(hwr_data.element - IW'(1))] <= idx_reg;
        end
        if (cmd.op == imhpq_pkg::CMD_LOAD)
        begin
            prd_reg <= pos_mem[AW'(req.element - IW'(1))];
        end
        else if (cmd.op == imhpq_pkg::CMD_FIN_A)
        begin
            prd_reg <= pos_mem[op_addr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (hwr_en)
            begin
                vld_reg[AW'(hwr_data.element - IW'(1))] <= 1'b1;
            end
            if (cmd.op == imhpq_pkg::CMD_RM_C)
            begin
                vld_reg[AW'(hrd_reg.element - IW'(1))] <= 1'b0;
                cnt_reg <= cnt_reg - IW'(1);
            end
            if (cmd.op == imhpq_pkg::CMD_INS)
            begin
                cnt_reg <= cnt_reg + IW'(1);
            end
            if (cmd.fin)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            imhpq_pkg::CMD_LOAD:
            begin
                op_reg <= req;
            end
            imhpq_pkg::CMD_INS:
            begin
                s_reg   <= '{element: op_reg.element, key: op_reg.key};
                idx_reg <= cnt_reg + IW'(1);
            end
            imhpq_pkg::CMD_CHG:
            begin
                s_reg   <= '{element: op_reg.element, key: op_reg.key};
                idx_reg <= prd_reg;
            end
            imhpq_pkg::CMD_RM_B:
            begin
                s_reg <= hrd_reg;
            end
            imhpq_pkg::CMD_RM_C:
            begin
                idx_reg <= IW'(1);
            end
            imhpq_pkg::CMD_UP_MOVE:
            begin
                idx_reg <= idx_reg >> 1;
            end
            imhpq_pkg::CMD_DN_L:
            begin
                c_reg    <= hrd_reg;
                cidx_reg <= IW'(dbl_idx);
            end
            imhpq_pkg::CMD_DN_TAKE_R:
            begin
                c_reg    <= hrd_reg;
                cidx_reg <= cidx_reg + IW'(1);
            end
            imhpq_pkg::CMD_DN_MOVE:
            begin
                idx_reg <= cidx_reg;
            end
            imhpq_pkg::CMD_FIN_B:
            begin
                root_reg <= hrd_reg;
            end
            default:
            begin
            end
        endcase
        if (cmd.fin)
        begin
            rsp_reg.status       <= cmd.status;
            rsp_reg.is_empty     <= (cnt_reg == '0);
            rsp_reg.count        <= cnt_reg;
            rsp_reg.min_element  <= (cnt_reg == '0) ? '0 : root_reg.element;
            rsp_reg.min_key      <= (cnt_reg == '0) ? '0 : root_reg.key;
            rsp_reg.elem_present <= present;
            rsp_reg.elem_key     <= present ? hrd_reg.key : '0;
        end
    end

    // status toward the controller
    always_comb
    begin
        stat.kind       = op_reg.kind;
        stat.id_ok      = (op_reg.element != '0) &&
                          (op_reg.element <= IW'(imhpq_pkg::MAX_ELEMENTS));
        stat.present    = present;
        stat.full       = (cnt_reg >= IW'(imhpq_pkg::MAX_ELEMENTS));
        stat.empty      = (cnt_reg == '0);
        stat.at_root    = (idx_reg == IW'(1));
        stat.no_child   = (dbl_idx > {1'b0, cnt_reg});
        stat.has_right  = ((dbl_idx + (IW+1)'(1)) <= {1'b0, cnt_reg});
        stat.hrd_gt_s   = (hrd_reg.key > s_reg.key);
        stat.key_lt_old = (op_reg.key < hrd_reg.key);
        stat.key_gt_old = (op_reg.key > hrd_reg.key);
        stat.right_lt   = (c_reg.key > hrd_reg.key);
        stat.s_gt_child = (s_reg.key > c_reg.key);
        stat.out_busy   = rsp_valid_reg && !rsp_ready;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // checks
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= IW'(imhpq_pkg::MAX_ELEMENTS))
        else $error("count above capacity");

    a_map_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == imhpq_pkg::CMD_LOAD) |-> ($countones(vld_reg) == int'(cnt_reg)))
        else $error("map occupancy differs from count");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.is_empty == (rsp_reg.count == '0)))
        else $error("empty flag disagrees with count");

endmodule

// File: rtl/indexed_min_heap_priority_queue_top.sv
// Indexed min-heap priority queue over element ids 1..256 with signed Q16.16
// keys. Each request (insert, remove minimum, change key, look up) yields one
// response with status, count, the current minimum and the named element's
// key. One request is processed at a time by a sequencer driving a heap
// memory with one read and one write port, so req_ready is high only while
// idle. A look up or a rejected request only refreshes the result; a key that
// rises moves up the heap level by level, a key that sinks moves down level by
// level, comparing against the smaller child (only the left one where no right
// child exists), and a removal first moves the last slot to the root. While a
// finished response is still held on the output, the sequencer re-reads its
// result.
module indexed_min_heap_priority_queue_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  imhpq_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output imhpq_pkg::rsp_t rsp
);

    imhpq_pkg::cmd_t  cmd;
    imhpq_pkg::stat_t stat;

    imhpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    imhpq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT = 1000000;

    logic            clk;
    logic            rst_n;
    logic            req_valid;
    logic            req_ready;
    imhpq_pkg::req_t req;
    logic            rsp_valid;
    logic            rsp_ready;
    imhpq_pkg::rsp_t rsp;

    indexed_min_heap_priority_queue_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // predictor state: heap slots, slot of each element, count
    logic [imhpq_pkg::ID_W-1:0]         hp_elem [1:imhpq_pkg::MAX_ELEMENTS];
    logic signed [imhpq_pkg::KEY_W-1:0] hp_key  [1:imhpq_pkg::MAX_ELEMENTS];
    int unsigned                        slot_of [0:imhpq_pkg::MAX_ELEMENTS];
    int unsigned                        held;

    imhpq_pkg::rsp_t expected_rsps[$];
    int              error_count;
    int              rsp_seen;
    int              sent_count;
    int unsigned     cycle_count;
    int              op_hist[4];
    int              status_hist[4];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // generous run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic void place(int unsigned i, logic [imhpq_pkg::ID_W-1:0] e,
                                  logic signed [imhpq_pkg::KEY_W-1:0] k);
        hp_elem[i] = e;
        hp_key[i]  = k;
        slot_of[e] = i;
    endfunction

    function automatic void sift_up(int unsigned i);
        logic [imhpq_pkg::ID_W-1:0]         e;
        logic signed [imhpq_pkg::KEY_W-1:0] k;
        e = hp_elem[i];
        k = hp_key[i];
        while (i > 1 && hp_key[i/2] > k)
        begin
            place(i, hp_elem[i/2], hp_key[i/2]);
            i = i / 2;
        end
        place(i, e, k);
    endfunction

    function automatic void sift_down(int unsigned i);
        logic [imhpq_pkg::ID_W-1:0]         e;
        logic signed [imhpq_pkg::KEY_W-1:0] k;
        int unsigned                        c;
        e = hp_elem[i];
        k = hp_key[i];
        forever
        begin
            c = 2 * i;
            if (c > held)
                break;
            if (c + 1 <= held && hp_key[c] > hp_key[c+1])
                c++;
            if (!(k > hp_key[c]))
                break;
            place(i, hp_elem[c], hp_key[c]);
            i = c;
        end
        place(i, e, k);
    endfunction

    // compute the response of one queue operation and update the heap
    function automatic imhpq_pkg::rsp_t heap_apply(imhpq_pkg::req_t r);
        imhpq_pkg::rsp_t                    o;
        bit                                 id_ok;
        bit                                 here;
        int unsigned                        i;
        logic signed [imhpq_pkg::KEY_W-1:0] old;
        logic [imhpq_pkg::ID_W-1:0]         le;
        logic signed [imhpq_pkg::KEY_W-1:0] lk;
        id_ok = r.element >= 1 && r.element <= imhpq_pkg::MAX_ELEMENTS;
        here  = id_ok && slot_of[r.element] != 0;
        o = '0;
        o.status = imhpq_pkg::ST_OK;
        case (r.kind)
            imhpq_pkg::KIND_INSERT:
            begin
                if (!id_ok || here || held >= imhpq_pkg::MAX_ELEMENTS)
                    o.status = imhpq_pkg::ST_FULL;
                else
                begin
                    held++;
                    place(held, r.element, r.key);
                    sift_up(held);
                end
            end
            imhpq_pkg::KIND_REMOVE:
            begin
                if (held == 0)
                    o.status = imhpq_pkg::ST_EMPTY;
                else
                begin
                    le = hp_elem[held];
                    lk = hp_key[held];
                    slot_of[hp_elem[1]] = 0;
                    held--;
                    if (held > 0)
                    begin
                        place(1, le, lk);
                        sift_down(1);
                    end
                end
            end
            imhpq_pkg::KIND_CHANGE:
            begin
                if (!here)
                    o.status = imhpq_pkg::ST_ABSENT;
                else
                begin
                    i = slot_of[r.element];
                    old = hp_key[i];
                    hp_key[i] = r.key;
                    if (r.key < old)
                        sift_up(i);
                    else if (r.key > old)
                        sift_down(i);
                end
            end
            default:
            begin
                if (!here)
                    o.status = imhpq_pkg::ST_ABSENT;
            end
        endcase
        here = id_ok && slot_of[r.element] != 0;
        o.is_empty     = held == 0;
        o.count        = held[imhpq_pkg::ID_W-1:0];
        o.min_element  = held ? hp_elem[1] : '0;
        o.min_key      = held ? hp_key[1] : '0;
        o.elem_present = here;
        o.elem_key     = here ? hp_key[slot_of[r.element]] : '0;
        return o;
    endfunction

    // short gaps mostly, a few long ones, sometimes none
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one transaction and record its expected response
    task automatic send_op(logic [1:0] kind, logic [imhpq_pkg::ID_W-1:0] e,
                           logic signed [imhpq_pkg::KEY_W-1:0] k);
        imhpq_pkg::req_t r;
        int              g;
        r.kind    = kind;
        r.element = e;
        r.key     = k;
        g = gap_len();
        if (g > 0)
        begin
            req_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        expected_rsps.push_back(heap_apply(r));
        op_hist[kind]++;
        sent_count++;
    endtask

    // drop valid and wait for every outstanding response
    task automatic wait_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_rsps.size() != 0);
    endtask

    // response stall pattern
    initial
    begin
        int g;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            g = gap_len();
            if (g == 0)
            begin
                rsp_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                rsp_ready <= 1'b0;
                repeat (g) @(posedge clk);
                rsp_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // response checker
    always @(posedge clk)
    begin
        imhpq_pkg::rsp_t x;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            rsp_seen++;
            if (expected_rsps.size() == 0)
            begin
                $error("unexpected response %h", rsp);
                error_count++;
            end
            else
            begin
                x = expected_rsps.pop_front();
                status_hist[x.status]++;
                if (rsp.status !== x.status)
                begin
                    $error("status exp %0d got %0d", x.status, rsp.status);
                    error_count++;
                end
                if (rsp.is_empty !== x.is_empty)
                begin
                    $error("is_empty exp %0d got %0d", x.is_empty, rsp.is_empty);
                    error_count++;
                end
                if (rsp.count !== x.count)
                begin
                    $error("count exp %0d got %0d", x.count, rsp.count);
                    error_count++;
                end
                if (rsp.min_element !== x.min_element)
                begin
                    $error("min_element exp %0d got %0d", x.min_element,
                           rsp.min_element);
                    error_count++;
                end
                if (rsp.min_key !== x.min_key)
                begin
                    $error("min_key exp %h got %h", x.min_key, rsp.min_key);
                    error_count++;
                end
                if (rsp.elem_present !== x.elem_present)
                begin
                    $error("elem_present exp %0d got %0d", x.elem_present,
                           rsp.elem_present);
                    error_count++;
                end
                if (rsp.elem_key !== x.elem_key)
                begin
                    $error("elem_key exp %h got %h", x.elem_key, rsp.elem_key);
                    error_count++;
                end
            end
        end
    end

    function automatic logic signed [imhpq_pkg::KEY_W-1:0] rand_key();
        int p;
        p = $urandom_range(0, 9);
        if (p < 4)
            return $signed($urandom_range(0, 15)) - 8;
        if (p == 4)
            return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
        return $urandom();
    endfunction

    function automatic logic [imhpq_pkg::ID_W-1:0] rand_elem(int unsigned span);
        if ($urandom_range(0, 49) == 0)
            return ($urandom_range(0, 1)) ? 9'd0 : 9'(($urandom_range(257, 511)));
        return 9'($urandom_range(1, span));
    endfunction

    // edge cases on an empty and a tiny queue
    task automatic test_directed();
        send_op(imhpq_pkg::KIND_REMOVE, 9'd5, '0);
        send_op(imhpq_pkg::KIND_LOOKUP, 9'd1, '0);
        send_op(imhpq_pkg::KIND_CHANGE, 9'd1, 32'sd7);
        send_op(imhpq_pkg::KIND_INSERT, 9'd0, 32'sd1);
        send_op(imhpq_pkg::KIND_INSERT, 9'd511, 32'sd1);
        send_op(imhpq_pkg::KIND_INSERT, 9'd256, 32'sh7fffffff);
        send_op(imhpq_pkg::KIND_INSERT, 9'd1, 32'sh80000000);
        send_op(imhpq_pkg::KIND_INSERT, 9'd1, 32'sd0);
        send_op(imhpq_pkg::KIND_INSERT, 9'd2, 32'sh80000000);
        send_op(imhpq_pkg::KIND_INSERT, 9'd3, 32'sd100);
        send_op(imhpq_pkg::KIND_CHANGE, 9'd3, 32'sd100);
        send_op(imhpq_pkg::KIND_CHANGE, 9'd256, 32'sh80000000);
        send_op(imhpq_pkg::KIND_CHANGE, 9'd1, 32'sh7fffffff);
        send_op(imhpq_pkg::KIND_LOOKUP, 9'd0, '0);
        send_op(imhpq_pkg::KIND_LOOKUP, 9'd300, '0);
        send_op(imhpq_pkg::KIND_LOOKUP, 9'd4, '0);
        send_op(imhpq_pkg::KIND_REMOVE, 9'd256, '0);
        send_op(imhpq_pkg::KIND_REMOVE, 9'd0, '0);
        send_op(imhpq_pkg::KIND_REMOVE, 9'd1, '0);
        send_op(imhpq_pkg::KIND_REMOVE, 9'd1, '0);
        send_op(imhpq_pkg::KIND_REMOVE, 9'd3, '0);
        send_op(imhpq_pkg::KIND_REMOVE, 9'd3, '0);
        wait_drained();
    endtask

    // fill to capacity, overflow, then empty in key order
    task automatic test_full_queue();
        int unsigned e;
        for (e = 1; e <= imhpq_pkg::MAX_ELEMENTS; e++)
            send_op(imhpq_pkg::KIND_INSERT, 9'(e), rand_key());
        send_op(imhpq_pkg::KIND_INSERT, 9'd17, 32'sd0);
        send_op(imhpq_pkg::KIND_CHANGE, 9'($urandom_range(1, 256)), rand_key());
        send_op(imhpq_pkg::KIND_LOOKUP, 9'($urandom_range(1, 256)), '0);
        // hold off until all responses are back
        wait_drained();
        while (held > 0)
            send_op(imhpq_pkg::KIND_REMOVE, 9'($urandom_range(0, 511)), '0);
        wait_drained();
    endtask

    // random mix, weighted per phase toward growth or shrinkage
    task automatic test_random_mix(int n, int unsigned span, int grow);
        int         i;
        int         p;
        logic [1:0] kind;
        for (i = 0; i < n; i++)
        begin
            p = $urandom_range(0, 99);
            if (p < grow)
                kind = imhpq_pkg::KIND_INSERT;
            else if (p < grow + 20)
                kind = imhpq_pkg::KIND_REMOVE;
            else if (p < grow + 50)
                kind = imhpq_pkg::KIND_CHANGE;
            else
                kind = imhpq_pkg::KIND_LOOKUP;
            send_op(kind, rand_elem(span), rand_key());
        end
    endtask

    initial
    begin
        int k;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        error_count = 0;
        rsp_seen    = 0;
        sent_count  = 0;
        cycle_count = 0;
        held        = 0;
        for (k = 0; k <= imhpq_pkg::MAX_ELEMENTS; k++)
            slot_of[k] = 0;
        for (k = 0; k < 4; k++)
        begin
            op_hist[k]     = 0;
            status_hist[k] = 0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_mix(300, 24, 40);
        test_full_queue();
        test_random_mix(300, 256, 45);
        test_random_mix(200, 256, 20);

        wait_drained();
        repeat (60) @(posedge clk);
        $display("covered %0d transactions: insert %0d remove %0d change %0d lookup %0d",
                 sent_count, op_hist[0], op_hist[1], op_hist[2], op_hist[3]);
        $display("statuses ok %0d full %0d empty %0d absent %0d, %0d responses",
                 status_hist[0], status_hist[1], status_hist[2], status_hist[3],
                 rsp_seen);
        if (error_count == 0 && expected_rsps.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// File: sim.f
rtl/imhpq_pkg.sv
rtl/imhpq_ctrl.sv
rtl/imhpq_dp.sv
rtl/indexed_min_heap_priority_queue_top.sv
bench/tb.sv
